// ===== rtl/kwm_pkg.sv =====
// Shared sizes, codes and types for the sorted lane merge.
package kwm_pkg;

   localparam int LANES        = 8;
   localparam int LANE_DEPTH   = 1024;

   localparam int VALUE_W      = 64;
   localparam int LANE_FIELD_W = 3;
   localparam int STATUS_W     = 2;
   localparam int REM_W        = 14;
   localparam int REM_MAX      = 16383;

   localparam int LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int PTR_W     = $clog2(LANE_DEPTH);
   localparam int CNT_W     = $clog2(LANE_DEPTH + 1);
   localparam int MEM_DEPTH = LANES * LANE_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int TOTAL_W   = $clog2(MEM_DEPTH + 1);
   localparam int SAT_W     = (TOTAL_W > REM_W) ? TOTAL_W : REM_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      OP_APPEND,
      OP_POP,
      OP_REJECT
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [LANE_W-1:0]    lane;
      logic [VALUE_W-1:0]   value;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_POP,
      BK_LOAD
   } back_state_type;

   // saturate the element count into the result field
   function automatic logic [REM_W-1:0] remain_field(input logic [TOTAL_W-1:0] total);
      logic [SAT_W-1:0] wide;
      wide = SAT_W'(total);
      if (wide > SAT_W'(REM_MAX)) begin
         remain_field = REM_W'(REM_MAX);
      end else begin
         remain_field = REM_W'(wide);
      end
   endfunction

endpackage

// ===== rtl/kwm_front.sv =====
// Front end: takes items, sorts them into append, pop or reject commands.
module kwm_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_mode,
   input  logic [kwm_pkg::LANE_FIELD_W-1:0] req_lane,
   input  logic [kwm_pkg::VALUE_W-1:0]      req_value,
   input  kwm_pkg::qstat_type               qstat,
   output logic                             q_push,
   output kwm_pkg::cmd_type                 q_cmd
);

   logic             slot_valid_ff;
   logic             slot_valid_in;
   kwm_pkg::cmd_type slot_ff;
   kwm_pkg::cmd_type slot_in;
   logic             accept;

   always_comb begin
      busy          = slot_valid_ff & qstat.full;
      accept        = start & ~busy;
      slot_valid_in = accept | (slot_valid_ff & qstat.full);
      q_push        = slot_valid_ff;
      q_cmd         = slot_ff;
   end

   // classify; a lane number beyond the lane count is refused outright
   always_comb begin
      slot_in.lane  = kwm_pkg::LANE_W'(req_lane);
      slot_in.value = req_value;
      if (req_mode) begin
         slot_in.op = kwm_pkg::OP_POP;
      end else if (int'(req_lane) < kwm_pkg::LANES) begin
         slot_in.op = kwm_pkg::OP_APPEND;
      end else begin
         slot_in.op = kwm_pkg::OP_REJECT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff <= slot_in;
      end
   end

endmodule

// ===== rtl/kwm_queue.sv =====
// Short command queue between the front end and the back end.
module kwm_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  kwm_pkg::cmd_type   push_cmd,
   input  logic               pop,
   output kwm_pkg::cmd_type   head_cmd,
   output kwm_pkg::qstat_type qstat
);

   kwm_pkg::cmd_type            q_ff [kwm_pkg::QUEUE_DEPTH];
   logic [kwm_pkg::QPTR_W-1:0]  wr_ptr_ff;
   logic [kwm_pkg::QPTR_W-1:0]  wr_ptr_in;
   logic [kwm_pkg::QPTR_W-1:0]  rd_ptr_ff;
   logic [kwm_pkg::QPTR_W-1:0]  rd_ptr_in;
   logic [kwm_pkg::QCNT_W-1:0]  cnt_ff;
   logic [kwm_pkg::QCNT_W-1:0]  cnt_in;
   logic                        do_push;
   logic                        do_pop;

   always_comb begin
      qstat.full  = (cnt_ff == kwm_pkg::QCNT_W'(kwm_pkg::QUEUE_DEPTH));
      qstat.empty = (cnt_ff == '0);
      do_push     = push & ~qstat.full;
      do_pop      = pop & ~qstat.empty;
      head_cmd    = q_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == kwm_pkg::QPTR_W'(kwm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == kwm_pkg::QPTR_W'(kwm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff;
      if (do_push & ~do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/kwm_back.sv =====
// Back end: lane store, cached heads, head scan and result register.
module kwm_back (
   input  logic                             clock,
   input  logic                             reset,
   input  kwm_pkg::qstat_type               qstat,
   input  kwm_pkg::cmd_type                 cmd,
   output logic                             q_pop,
   output logic                             rsp_valid,
   output logic [kwm_pkg::VALUE_W-1:0]      rsp_merged_value,
   output logic [kwm_pkg::LANE_FIELD_W-1:0] rsp_source_lane,
   output logic [kwm_pkg::STATUS_W-1:0]     rsp_status,
   output logic [kwm_pkg::REM_W-1:0]        rsp_remaining
);

   kwm_pkg::back_state_type state_ff;
   kwm_pkg::back_state_type state_in;

   // lane store, reset undefined: only written entries are used
   logic [kwm_pkg::VALUE_W-1:0] mem [kwm_pkg::MEM_DEPTH];
   logic [kwm_pkg::VALUE_W-1:0] rd_data_ff;
   logic [kwm_pkg::ADDR_W-1:0]  wr_addr;
   logic [kwm_pkg::ADDR_W-1:0]  rd_addr;

   logic [kwm_pkg::PTR_W-1:0]   rp_ff   [kwm_pkg::LANES];
   logic [kwm_pkg::CNT_W-1:0]   wc_ff   [kwm_pkg::LANES];
   logic [kwm_pkg::VALUE_W-1:0] head_ff [kwm_pkg::LANES];
   logic [kwm_pkg::TOTAL_W-1:0] total_ff;

   logic [kwm_pkg::LANE_W-1:0]  scan_ff;
   logic                        found_ff;
   logic [kwm_pkg::LANE_W-1:0]  best_lane_ff;
   logic [kwm_pkg::VALUE_W-1:0] best_val_ff;

   logic                        rsp_valid_ff;
   logic [kwm_pkg::VALUE_W-1:0]      rsp_value_ff;
   logic [kwm_pkg::LANE_FIELD_W-1:0] rsp_lane_ff;
   logic [kwm_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [kwm_pkg::REM_W-1:0]        rsp_rem_ff;

   // decoded controls
   logic app_ok;
   logic app_fail;
   logic pop_empty;
   logic start_scan;
   logic scan_step;
   logic pop_commit;
   logic head_reload;

   logic                        lane_full;
   logic                        scan_last;
   logic                        scan_hit;
   logic [kwm_pkg::CNT_W-1:0]   rp_next;
   logic                        drained;

   always_comb begin
      lane_full = (wc_ff[cmd.lane] >= kwm_pkg::CNT_W'(kwm_pkg::LANE_DEPTH));
      scan_last = (scan_ff == kwm_pkg::LANE_W'(kwm_pkg::LANES - 1));
      scan_hit  = (wc_ff[scan_ff] != '0) &
                  (~found_ff | (head_ff[scan_ff] < best_val_ff));
      rp_next   = kwm_pkg::CNT_W'(rp_ff[best_lane_ff]) + kwm_pkg::CNT_W'(1);
      drained   = (rp_next >= wc_ff[best_lane_ff]);
      wr_addr   = kwm_pkg::ADDR_W'(cmd.lane) * kwm_pkg::ADDR_W'(kwm_pkg::LANE_DEPTH) +
                  kwm_pkg::ADDR_W'(wc_ff[cmd.lane]);
      rd_addr   = kwm_pkg::ADDR_W'(best_lane_ff) * kwm_pkg::ADDR_W'(kwm_pkg::LANE_DEPTH) +
                  kwm_pkg::ADDR_W'(rp_next);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kwm_pkg::BK_IDLE: begin
            if (!qstat.empty && cmd.op == kwm_pkg::OP_POP && total_ff != '0) begin
               state_in = kwm_pkg::BK_SCAN;
            end
         end
         kwm_pkg::BK_SCAN: begin
            if (scan_last) begin
               state_in = kwm_pkg::BK_POP;
            end
         end
         kwm_pkg::BK_POP: begin
            state_in = drained ? kwm_pkg::BK_IDLE : kwm_pkg::BK_LOAD;
         end
         kwm_pkg::BK_LOAD: begin
            state_in = kwm_pkg::BK_IDLE;
         end
         default: begin
            state_in = kwm_pkg::BK_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      q_pop       = 1'b0;
      app_ok      = 1'b0;
      app_fail    = 1'b0;
      pop_empty   = 1'b0;
      start_scan  = 1'b0;
      scan_step   = 1'b0;
      pop_commit  = 1'b0;
      head_reload = 1'b0;
      case (state_ff)
         kwm_pkg::BK_IDLE: begin
            if (!qstat.empty) begin
               q_pop = 1'b1;
               case (cmd.op)
                  kwm_pkg::OP_APPEND: begin
                     app_ok   = ~lane_full;
                     app_fail = lane_full;
                  end
                  kwm_pkg::OP_POP: begin
                     pop_empty  = (total_ff == '0);
                     start_scan = (total_ff != '0);
                  end
                  default: begin
                     app_fail = 1'b1;
                  end
               endcase
            end
         end
         kwm_pkg::BK_SCAN: begin
            scan_step = 1'b1;
         end
         kwm_pkg::BK_POP: begin
            pop_commit = 1'b1;
         end
         kwm_pkg::BK_LOAD: begin
            head_reload = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kwm_pkg::BK_IDLE;
         total_ff     <= '0;
         scan_ff      <= '0;
         found_ff     <= 1'b0;
         best_lane_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < kwm_pkg::LANES; i++) begin
            rp_ff[i] <= '0;
            wc_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= app_ok | app_fail | pop_empty | pop_commit;
         if (app_ok) begin
            wc_ff[cmd.lane] <= wc_ff[cmd.lane] + 1'b1;
            total_ff        <= total_ff + 1'b1;
         end
         if (start_scan) begin
            scan_ff  <= '0;
            found_ff <= 1'b0;
         end
         if (scan_step) begin
            if (!scan_last) begin
               scan_ff <= scan_ff + 1'b1;
            end
            if (scan_hit) begin
               found_ff     <= 1'b1;
               best_lane_ff <= scan_ff;
            end
         end
         if (pop_commit) begin
            total_ff <= total_ff - 1'b1;
            if (drained) begin
               rp_ff[best_lane_ff] <= '0;
               wc_ff[best_lane_ff] <= '0;
            end else begin
               rp_ff[best_lane_ff] <= kwm_pkg::PTR_W'(rp_next);
            end
         end
      end
   end

   // payload: heads, best candidate, result fields
   always_ff @(posedge clock) begin
      if (app_ok && wc_ff[cmd.lane] == '0) begin
         head_ff[cmd.lane] <= cmd.value;
      end
      if (head_reload) begin
         head_ff[best_lane_ff] <= rd_data_ff;
      end
      if (scan_step && scan_hit) begin
         best_val_ff <= head_ff[scan_ff];
      end
      if (app_ok) begin
         rsp_value_ff  <= '0;
         rsp_lane_ff   <= '0;
         rsp_status_ff <= kwm_pkg::ST_OK;
         rsp_rem_ff    <= kwm_pkg::remain_field(total_ff + 1'b1);
      end else if (app_fail) begin
         rsp_value_ff  <= '0;
         rsp_lane_ff   <= '0;
         rsp_status_ff <= kwm_pkg::ST_FULL;
         rsp_rem_ff    <= kwm_pkg::remain_field(total_ff);
      end else if (pop_empty) begin
         rsp_value_ff  <= '0;
         rsp_lane_ff   <= '0;
         rsp_status_ff <= kwm_pkg::ST_EMPTY;
         rsp_rem_ff    <= kwm_pkg::remain_field(total_ff);
      end else if (pop_commit) begin
         rsp_value_ff  <= best_val_ff;
         rsp_lane_ff   <= kwm_pkg::LANE_FIELD_W'(best_lane_ff);
         rsp_status_ff <= kwm_pkg::ST_OK;
         rsp_rem_ff    <= kwm_pkg::remain_field(total_ff - 1'b1);
      end
   end

   // lane store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (app_ok) begin
         mem[wr_addr] <= cmd.value;
      end
      if (pop_commit) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      rsp_valid        = rsp_valid_ff;
      rsp_merged_value = rsp_value_ff;
      rsp_source_lane  = rsp_lane_ff;
      rsp_status       = rsp_status_ff;
      rsp_remaining    = rsp_rem_ff;
   end

endmodule

// ===== rtl/k_way_sorted_lane_merge.sv =====
// Top level of the k-way sorted lane merge: front end, queue, back end.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  -------------------------------
//  request   req_mode, req_lane, req_value           taken when start high, busy low
//  response  rsp_merged_value, rsp_source_lane,      one cycle, marked by rsp_valid
//            rsp_status, rsp_remaining
//
// The result strobe is registered: a taken item passes the front slot and the queue first.
// Appends, refused items and pops on an empty store are answered from dispatch; any
// other pop steps through dispatch, one cached head per scan cycle, commit with the
// store read, head reload (no reload when the pop drains its lane).
// Reset is synchronous and empties every lane; the store itself needs no clearing.
// The receiver cannot stall; busy rises only when queue and front slot are both full.
module k_way_sorted_lane_merge (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_mode,
   input  logic [kwm_pkg::LANE_FIELD_W-1:0] req_lane,
   input  logic [kwm_pkg::VALUE_W-1:0]      req_value,
   output logic                             rsp_valid,
   output logic [kwm_pkg::VALUE_W-1:0]      rsp_merged_value,
   output logic [kwm_pkg::LANE_FIELD_W-1:0] rsp_source_lane,
   output logic [kwm_pkg::STATUS_W-1:0]     rsp_status,
   output logic [kwm_pkg::REM_W-1:0]        rsp_remaining
);

   kwm_pkg::qstat_type qstat;
   kwm_pkg::cmd_type   push_cmd;
   kwm_pkg::cmd_type   head_cmd;
   logic               q_push;
   logic               q_pop;

   // front end: classifies items and holds one in its slot
   kwm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_mode  (req_mode),
      .req_lane  (req_lane),
      .req_value (req_value),
      .qstat     (qstat),
      .q_push    (q_push),
      .q_cmd     (push_cmd)
   );

   // decoupling queue
   kwm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .qstat    (qstat)
   );

   // back end: lanes, head cache, scan and result register
   kwm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .qstat            (qstat),
      .cmd              (head_cmd),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_merged_value (rsp_merged_value),
      .rsp_source_lane  (rsp_source_lane),
      .rsp_status       (rsp_status),
      .rsp_remaining    (rsp_remaining)
   );

endmodule
